// ===== hw/rtl/ilha_pkg.sv =====
package ilha_pkg;

	// Field widths of the request and response words.
	localparam int BYTES_W = 16;
	localparam int ADDR_W  = 17;

	// Block sizes and heap positions are bounded by the 13-bit heap limit register.
	localparam int SIZE_W = 13;
	localparam int HDR_W  = SIZE_W + 1;
	localparam int POS_W  = SIZE_W + 1;

	// Default number of granules in the header store.
	localparam int HEAP_GRANULES_DEF = 4096;

	// Header overhead (8 bytes) plus rounding to a 16-byte granule.
	localparam int NEED_ROUND = 23;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic               REG_HEAP_LIMIT = 1'b0;
	localparam logic [SIZE_W-1:0]  LIMIT_RESET    = 13'd4096;

	// Command codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Status codes.
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOM = 1'b1;

	typedef enum logic [1:0] {
		RD_POS,
		RD_NXT,
		RD_FREE
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_MERGE,
		WR_FIT,
		WR_SPLIT,
		WR_EXT,
		WR_FREE
	} wr_sel_t;

	typedef struct packed {
		logic    load_in;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    pos_clear;
		logic    pos_adv;
		logic    pos_from_nxt;
		logic    run_start;
		logic    run_add;
		logic    top_grow;
		logic    res_fit;
		logic    res_ext;
		logic    res_fail;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic pos_end;
		logic nxt_end;
		logic hdr_used;
		logic fits;
		logic split;
		logic ext_fail;
		logic free_ok;
	} dp_stat_t;

endpackage

// ===== hw/rtl/ilha_intf.sv =====
interface ilha_req_if
	import ilha_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               command;
	logic [BYTES_W-1:0] request_bytes;
	logic [ADDR_W-1:0]  payload_address;

	modport source (output valid, output command, output request_bytes,
		output payload_address, input ready);
	modport sink (input valid, input command, input request_bytes,
		input payload_address, output ready);
endinterface

interface ilha_rsp_if
	import ilha_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] result_address;
	logic              status;

	modport source (output valid, output result_address, output status, input ready);
	modport sink (input valid, input result_address, input status, output ready);
endinterface

// ===== hw/rtl/implicit_list_heap_allocator.sv =====
// Channel   Role     Word contents
// -------   ------   ---------------------------------------------------
// req       sink     command, request_bytes, payload_address
// rsp       source   result_address, status
// APB       slave    heap_limit_granules at byte address 0 (13 bits)
//
// One request at a time. After a request is accepted, a free reads the block's header and
// writes it back as free, skipping both when its address is null or past the store. An
// allocate reads each header in its merge and first-fit passes, writes one merged header
// per free run, then splits a fitting block, extends the heap or fails, and loads the
// result register; the next word can be taken in the cycle after that load. Reset empties
// the heap with no clearing pass. A waiting result stalls only the next result, which
// holds the block in its response state, taking no word, until the first is taken.
module implicit_list_heap_allocator
	import ilha_pkg::*;
#(
	parameter int HEAP_GRANULES = HEAP_GRANULES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	ilha_req_if.sink           req,
	ilha_rsp_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [SIZE_W-1:0] heap_limit_q;
	logic              reg_sel;

	// The register index is the word address; the low byte bits are ignored.
	assign reg_sel = (paddr[2] == REG_HEAP_LIMIT);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? PDATA_W'(heap_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			heap_limit_q <= pwdata[SIZE_W-1:0];
		end
	end

	// The controller sequences the merge and fit walks; the datapath holds
	// the header store, walk pointers and the output register.
	ilha_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_command (req.command),
		.in_ready   (req.ready),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	ilha_dp #(
		.HEAP_GRANULES (HEAP_GRANULES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.in_command         (req.command),
		.in_request_bytes   (req.request_bytes),
		.in_payload_address (req.payload_address),
		.heap_limit         (heap_limit_q),
		.out_result_address (rsp.result_address),
		.out_status         (rsp.status)
	);

endmodule

// ===== hw/rtl/ilha_dp.sv =====
module ilha_dp
	import ilha_pkg::*;
#(
	parameter int HEAP_GRANULES = HEAP_GRANULES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic               in_command,
	input  logic [BYTES_W-1:0] in_request_bytes,
	input  logic [ADDR_W-1:0]  in_payload_address,
	input  logic [SIZE_W-1:0]  heap_limit,
	output logic [ADDR_W-1:0]  out_result_address,
	output logic               out_status
);

	localparam int IDX_W = $clog2(HEAP_GRANULES);
	localparam logic [ADDR_W-1:0] GRANULES_A = ADDR_W'(HEAP_GRANULES);

	logic [HDR_W-1:0]  hdr_mem [HEAP_GRANULES];
	logic [HDR_W-1:0]  rd_q;

	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  nxt_q;
	logic [SIZE_W-1:0] total_q;
	logic [SIZE_W-1:0] top_q;
	logic [SIZE_W-1:0] need_q;
	logic [SIZE_W-1:0] free_g_q;
	logic              free_ok_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              res_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic              out_status_q;

	logic [SIZE_W-1:0] hsize;
	logic [SIZE_W-1:0] limit_eff;
	logic [ADDR_W-1:0] need_sum;
	logic [SIZE_W-1:0] in_gran;
	logic [SIZE_W-1:0] in_free_g;
	logic [POS_W-1:0]  pos_next;
	logic [POS_W-1:0]  nxt_next;
	logic [SIZE_W-1:0] pos_inc;
	logic [IDX_W-1:0]  rd_idx;
	logic [IDX_W-1:0]  wr_idx;
	logic [HDR_W-1:0]  wr_data;

	// A zero-size header still advances a walk by one granule.
	assign hsize = (rd_q[HDR_W-1:1] == '0) ? SIZE_W'(1) : rd_q[HDR_W-1:1];

	assign limit_eff = ({{(ADDR_W-SIZE_W){1'b0}}, heap_limit} > GRANULES_A)
		? GRANULES_A[SIZE_W-1:0] : heap_limit;

	assign need_sum  = ADDR_W'(in_request_bytes) + ADDR_W'(NEED_ROUND);
	assign in_gran   = in_payload_address[ADDR_W-1:4];
	assign in_free_g = in_gran - SIZE_W'(1);

	assign pos_next = pos_q + POS_W'(hsize);
	assign nxt_next = nxt_q + POS_W'(hsize);
	assign pos_inc  = pos_q[SIZE_W-1:0] + SIZE_W'(1);

	assign stat.pos_end  = pos_q >= POS_W'(top_q);
	assign stat.nxt_end  = nxt_q >= POS_W'(top_q);
	assign stat.hdr_used = rd_q[0];
	assign stat.fits     = !rd_q[0] && (hsize >= need_q);
	assign stat.split    = hsize > need_q;
	assign stat.ext_fail = (POS_W'(top_q) + POS_W'(need_q)) > POS_W'(limit_eff);
	assign stat.free_ok  = free_ok_q;

	always_comb begin
		case (cmd.rd_sel)
			RD_NXT:  rd_idx = IDX_W'(nxt_q);
			RD_FREE: rd_idx = IDX_W'(free_g_q);
			default: rd_idx = IDX_W'(pos_q);
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_MERGE: begin
				wr_idx  = IDX_W'(pos_q);
				wr_data = {total_q, 1'b0};
			end
			WR_FIT: begin
				wr_idx  = IDX_W'(pos_q);
				wr_data = {need_q, 1'b1};
			end
			WR_SPLIT: begin
				wr_idx  = IDX_W'(pos_q + POS_W'(need_q));
				wr_data = {hsize - need_q, 1'b0};
			end
			WR_EXT: begin
				wr_idx  = IDX_W'(top_q);
				wr_data = {need_q, 1'b1};
			end
			default: begin
				wr_idx  = IDX_W'(free_g_q);
				wr_data = {rd_q[HDR_W-1:1], 1'b0};
			end
		endcase
	end

	// Header store with separate read and write addresses and registered read data.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			hdr_mem[wr_idx] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= hdr_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (cmd.top_grow) begin
			top_q <= top_q + need_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			need_q       <= need_sum[ADDR_W-1:4];
			free_g_q     <= in_free_g;
			free_ok_q    <= (in_command == CMD_FREE) && (in_gran != '0)
				&& ({{(ADDR_W-SIZE_W){1'b0}}, in_free_g} < GRANULES_A);
			res_addr_q   <= '0;
			res_status_q <= STATUS_OK;
		end else if (cmd.res_fit) begin
			res_addr_q   <= {pos_inc, 4'b0000};
			res_status_q <= STATUS_OK;
		end else if (cmd.res_ext) begin
			res_addr_q   <= {top_q + SIZE_W'(1), 4'b0000};
			res_status_q <= STATUS_OK;
		end else if (cmd.res_fail) begin
			res_addr_q   <= '0;
			res_status_q <= STATUS_OOM;
		end

		if (cmd.load_in || cmd.pos_clear) begin
			pos_q <= '0;
		end else if (cmd.pos_adv) begin
			pos_q <= pos_next;
		end else if (cmd.pos_from_nxt) begin
			pos_q <= nxt_q;
		end

		if (cmd.run_start) begin
			total_q <= hsize;
			nxt_q   <= pos_next;
		end else if (cmd.run_add) begin
			total_q <= total_q + hsize;
			nxt_q   <= nxt_next;
		end

		if (cmd.out_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_result_address = out_addr_q;
	assign out_status         = out_status_q;

endmodule

// ===== hw/rtl/ilha_ctrl.sv =====
module ilha_ctrl
	import ilha_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_command,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_FR_RD   = 13'b0000000000010,
		S_FR_WR   = 13'b0000000000100,
		S_M_RD    = 13'b0000000001000,
		S_M_EV    = 13'b0000000010000,
		S_M_NRD   = 13'b0000000100000,
		S_M_NEV   = 13'b0000001000000,
		S_M_WR    = 13'b0000010000000,
		S_F_RD    = 13'b0000100000000,
		S_F_EV    = 13'b0001000000000,
		S_F_SPLIT = 13'b0010000000000,
		S_EXT     = 13'b0100000000000,
		S_RESP    = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = (in_command == CMD_FREE) ? S_FR_RD : S_M_RD;
				end
			end
			S_FR_RD: begin
				if (stat.free_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_FREE;
					state_d = S_FR_WR;
				end else begin
					state_d = S_RESP;
				end
			end
			S_FR_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_FREE;
				state_d = S_RESP;
			end
			S_M_RD: begin
				if (stat.pos_end) begin
					cmd.pos_clear = 1'b1;
					state_d = S_F_RD;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_POS;
					state_d = S_M_EV;
				end
			end
			S_M_EV: begin
				if (stat.hdr_used) begin
					cmd.pos_adv = 1'b1;
					state_d = S_M_RD;
				end else begin
					cmd.run_start = 1'b1;
					state_d = S_M_NRD;
				end
			end
			S_M_NRD: begin
				if (stat.nxt_end) begin
					state_d = S_M_WR;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NXT;
					state_d = S_M_NEV;
				end
			end
			S_M_NEV: begin
				if (stat.hdr_used) begin
					state_d = S_M_WR;
				end else begin
					cmd.run_add = 1'b1;
					state_d = S_M_NRD;
				end
			end
			S_M_WR: begin
				cmd.wr_en        = 1'b1;
				cmd.wr_sel       = WR_MERGE;
				cmd.pos_from_nxt = 1'b1;
				state_d = S_M_RD;
			end
			S_F_RD: begin
				if (stat.pos_end) begin
					state_d = S_EXT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_POS;
					state_d = S_F_EV;
				end
			end
			S_F_EV: begin
				if (stat.fits) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = WR_FIT;
					cmd.res_fit = 1'b1;
					state_d = stat.split ? S_F_SPLIT : S_RESP;
				end else begin
					cmd.pos_adv = 1'b1;
					state_d = S_F_RD;
				end
			end
			S_F_SPLIT: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SPLIT;
				state_d = S_RESP;
			end
			S_EXT: begin
				if (stat.ext_fail) begin
					cmd.res_fail = 1'b1;
				end else begin
					cmd.wr_en    = 1'b1;
					cmd.wr_sel   = WR_EXT;
					cmd.res_ext  = 1'b1;
					cmd.top_grow = 1'b1;
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
